// ===== src/abkf_pkg.sv =====
// Shared types, register indexes and arithmetic helpers for the angle/bias Kalman filter.
package abkf_pkg;

    localparam int RegW = 31;
    localparam int DataW = 32;
    localparam int AddrW = 4;

    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd2;
    localparam logic [1:0] REG_STEP = 2'd3;

    localparam logic [RegW-1:0] ANGLE_NOISE_RST = 31'd1073742;
    localparam logic [RegW-1:0] BIAS_NOISE_RST = 31'd3221225;
    localparam logic [RegW-1:0] MEAS_NOISE_RST = 31'd32212255;
    localparam logic [RegW-1:0] STEP_RST = 31'd10737418;

    // datapath operations issued by the controller
    localparam logic [4:0] OP_NONE = 5'd0;
    localparam logic [4:0] OP_LOAD = 5'd1;
    localparam logic [4:0] OP_M_RATE = 5'd2;   // prod = rate*dt
    localparam logic [4:0] OP_ANGLE = 5'd3;    // angle += prod
    localparam logic [4:0] OP_M_DTBB = 5'd4;   // prod = dt*cov_bb
    localparam logic [4:0] OP_T = 5'd5;        // t, keep dt*bb
    localparam logic [4:0] OP_M_DTT = 5'd6;    // prod = dt*t
    localparam logic [4:0] OP_AA = 5'd7;
    localparam logic [4:0] OP_M_BN = 5'd8;     // prod = bias_noise*dt
    localparam logic [4:0] OP_BB = 5'd9;       // cov_bb, ab, ba; S; y
    localparam logic [4:0] OP_DIV_START = 5'd10;
    localparam logic [4:0] OP_DIV_STEP = 5'd11;
    localparam logic [4:0] OP_DIV_DONE = 5'd12;
    localparam logic [4:0] OP_M_K0Y = 5'd13;
    localparam logic [4:0] OP_UP_ANGLE = 5'd14;
    localparam logic [4:0] OP_M_K1Y = 5'd15;
    localparam logic [4:0] OP_UP_BIAS = 5'd16;
    localparam logic [4:0] OP_M_K0AA = 5'd17;
    localparam logic [4:0] OP_UP_AA = 5'd18;
    localparam logic [4:0] OP_M_K0AB = 5'd19;
    localparam logic [4:0] OP_UP_AB = 5'd20;
    localparam logic [4:0] OP_M_K1AA = 5'd21;
    localparam logic [4:0] OP_UP_BA = 5'd22;
    localparam logic [4:0] OP_M_K1AB = 5'd23;
    localparam logic [4:0] OP_UP_BB = 5'd24;

    typedef struct packed {
        logic [4:0] op;
        logic       div_sel;   // 0: gain k0, 1: gain k1
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // round half up, drop 30 fraction bits; 64-bit product gives a 34-bit result
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
        logic signed [64:0] s;
        s = {p[63], p} + 65'sd536870912;
        return s[63:30];
    endfunction

endpackage

// ===== src/angle_bias_kalman_filter.sv =====
// Top level of the two-state angle/bias Kalman filter with its APB register file.
//
//  channel   | handshake                | words
//  input     | i_in_valid / o_in_ready  | i_measured_angle, i_measured_rate
//  output    | o_out_valid / i_out_ready| o_filtered_angle
//  config    | APB psel/penable/pwrite  | 4 registers at 0x0..0xC
//
// Each word is processed by 10 multiplies on one shared 32x32 multiplier, a sequence of
// load/accumulate/sequencing steps and two 62-step restoring divisions for the gains.
// Synchronous active-low reset clears the state; registers return to defaults.
// A new word is taken only after the result has been taken by the output side.
module angle_bias_kalman_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [24:0]                i_measured_angle,
    input  logic signed [25:0]                i_measured_rate,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [31:0]                o_filtered_angle,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [abkf_pkg::AddrW-1:0]        paddr,
    input  logic [abkf_pkg::DataW-1:0]        pwdata,
    output logic [abkf_pkg::DataW-1:0]        prdata,
    output logic                              pready
);

    logic [abkf_pkg::RegW-1:0] r_angle_noise, r_bias_noise, r_meas_noise, r_step;
    abkf_pkg::t_cmd    cmd;
    abkf_pkg::t_status status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_noise <= abkf_pkg::ANGLE_NOISE_RST;
            r_bias_noise <= abkf_pkg::BIAS_NOISE_RST;
            r_meas_noise <= abkf_pkg::MEAS_NOISE_RST;
            r_step <= abkf_pkg::STEP_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                abkf_pkg::REG_ANGLE_NOISE: r_angle_noise <= pwdata[30:0];
                abkf_pkg::REG_BIAS_NOISE:  r_bias_noise <= pwdata[30:0];
                abkf_pkg::REG_MEAS_NOISE:  r_meas_noise <= pwdata[30:0];
                abkf_pkg::REG_STEP:        r_step <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            abkf_pkg::REG_ANGLE_NOISE: prdata = {1'b0, r_angle_noise};
            abkf_pkg::REG_BIAS_NOISE:  prdata = {1'b0, r_bias_noise};
            abkf_pkg::REG_MEAS_NOISE:  prdata = {1'b0, r_meas_noise};
            abkf_pkg::REG_STEP:        prdata = {1'b0, r_step};
            default:                   prdata = '0;
        endcase
    end

    abkf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    abkf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_measured_angle (i_measured_angle),
        .i_measured_rate  (i_measured_rate),
        .i_angle_noise    (r_angle_noise),
        .i_bias_noise     (r_bias_noise),
        .i_measure_noise  (r_meas_noise),
        .i_step_seconds   (r_step),
        .o_filtered_angle (o_filtered_angle)
    );

endmodule

// ===== src/abkf_ctrl.sv =====
// Sequencer for the predict and update steps of the angle/bias Kalman filter.
module abkf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  abkf_pkg::t_status    i_status,
    output abkf_pkg::t_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN = 2'd1;
    localparam logic [1:0] S_DIV = 2'd2;
    localparam logic [1:0] S_OUT = 2'd3;

    logic [1:0] r_state, n_state;
    logic [4:0] r_op, n_op;
    logic       r_sel, n_sel;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_sel = r_sel;
        o_cmd.op = abkf_pkg::OP_NONE;
        o_cmd.div_sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = abkf_pkg::OP_LOAD;
                    n_op = abkf_pkg::OP_M_RATE;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.op = r_op;
                if (r_op == abkf_pkg::OP_DIV_START) begin
                    n_state = S_DIV;
                end else if (r_op == abkf_pkg::OP_DIV_DONE) begin
                    if (r_sel) begin
                        n_sel = 1'b0;
                        n_op = abkf_pkg::OP_M_K0Y;
                    end else begin
                        n_sel = 1'b1;
                        n_op = abkf_pkg::OP_DIV_START;
                    end
                end else if (r_op == abkf_pkg::OP_UP_BB) begin
                    n_state = S_OUT;
                end else begin
                    n_op = r_op + 5'd1;
                end
            end
            S_DIV: begin
                o_cmd.op = abkf_pkg::OP_DIV_STEP;
                if (i_status.div_done) begin
                    n_op = abkf_pkg::OP_DIV_DONE;
                    n_state = S_RUN;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op <= abkf_pkg::OP_NONE;
            r_sel <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
            r_sel <= n_sel;
        end
    end

endmodule

// ===== src/abkf_dp.sv =====
// Filter state, shared multiplier and restoring gain divider.
module abkf_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  abkf_pkg::t_cmd              i_cmd,
    output abkf_pkg::t_status           o_status,
    input  logic signed [24:0]          i_measured_angle,
    input  logic signed [25:0]          i_measured_rate,
    input  logic [abkf_pkg::RegW-1:0]   i_angle_noise,
    input  logic [abkf_pkg::RegW-1:0]   i_bias_noise,
    input  logic [abkf_pkg::RegW-1:0]   i_measure_noise,
    input  logic [abkf_pkg::RegW-1:0]   i_step_seconds,
    output logic signed [31:0]          o_filtered_angle
);

    logic signed [31:0] r_angle, r_bias, r_aa, r_ab, r_ba, r_bb;
    logic signed [31:0] r_rate, r_meas, r_y, r_t, r_k0, r_k1, r_aa_old, r_ab_old;
    logic signed [33:0] r_prod, r_dtbb;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [32:0] r_s;
    logic               r_s_pos;
    // divider: |num| * 2^30 / S, 62-bit dividend, one quotient bit per cycle
    logic [61:0]        r_rem_num;
    logic [32:0]        r_rem;
    logic [61:0]        r_quo;
    logic [5:0]         r_cnt;
    logic               r_neg;
    logic [33:0]        trial;
    logic [32:0]        div_num_mag;
    logic signed [31:0] div_num;
    logic signed [31:0] gain_q;
    logic signed [31:0] dt;

    assign dt = {1'b0, i_step_seconds};
    assign mul_p = mul_a * mul_b;
    assign o_filtered_angle = r_angle;
    assign o_status.div_done = (r_cnt == 6'd61);

    always_comb begin
        mul_a = dt;
        mul_b = r_rate;
        case (i_cmd.op)
            abkf_pkg::OP_M_RATE: begin mul_a = r_rate; mul_b = dt; end
            abkf_pkg::OP_M_DTBB: begin mul_a = dt; mul_b = r_bb; end
            abkf_pkg::OP_M_DTT:  begin mul_a = dt; mul_b = r_t; end
            abkf_pkg::OP_M_BN:   begin mul_a = {1'b0, i_bias_noise}; mul_b = dt; end
            abkf_pkg::OP_M_K0Y:  begin mul_a = r_k0; mul_b = r_y; end
            abkf_pkg::OP_M_K1Y:  begin mul_a = r_k1; mul_b = r_y; end
            abkf_pkg::OP_M_K0AA: begin mul_a = r_k0; mul_b = r_aa_old; end
            abkf_pkg::OP_M_K0AB: begin mul_a = r_k0; mul_b = r_ab_old; end
            abkf_pkg::OP_M_K1AA: begin mul_a = r_k1; mul_b = r_aa_old; end
            abkf_pkg::OP_M_K1AB: begin mul_a = r_k1; mul_b = r_ab_old; end
            default: begin mul_a = dt; mul_b = r_rate; end
        endcase
    end

    always_comb begin
        div_num = i_cmd.div_sel ? r_ba : r_aa;
        div_num_mag = div_num[31] ? 33'(-{div_num[31], div_num}) : {1'b0, div_num};
        trial = {r_rem, r_rem_num[61]} - {1'b0, r_s};
        // quotient magnitude is below 2^62; saturate to 32 bits with sign
        if (!r_s_pos) begin
            gain_q = 32'sd0;
        end else if (r_neg) begin
            gain_q = (r_quo > 62'd2147483648) ? 32'sh80000000 : 32'(-r_quo[31:0]);
        end else begin
            gain_q = (r_quo > 62'd2147483647) ? 32'sh7fffffff : r_quo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_bias <= '0;
            r_aa <= '0;
            r_ab <= '0;
            r_ba <= '0;
            r_bb <= '0;
            r_cnt <= '0;
        end else begin
            case (i_cmd.op)
                abkf_pkg::OP_LOAD: begin
                    r_rate <= abkf_pkg::sat32(35'(i_measured_rate) - 35'(r_bias));
                    r_meas <= 32'(i_measured_angle);
                end
                abkf_pkg::OP_M_RATE, abkf_pkg::OP_M_DTBB, abkf_pkg::OP_M_DTT,
                abkf_pkg::OP_M_BN, abkf_pkg::OP_M_K0Y, abkf_pkg::OP_M_K1Y,
                abkf_pkg::OP_M_K0AA, abkf_pkg::OP_M_K0AB, abkf_pkg::OP_M_K1AA,
                abkf_pkg::OP_M_K1AB: begin
                    r_prod <= abkf_pkg::rnd30(mul_p);
                end
                abkf_pkg::OP_ANGLE: begin
                    r_angle <= abkf_pkg::sat32(35'(r_angle) + 35'(r_prod));
                end
                abkf_pkg::OP_T: begin
                    r_dtbb <= r_prod;
                    r_t <= abkf_pkg::sat32(35'(r_prod) - 35'(r_ab) - 35'(r_ba)
                                           + 35'({1'b0, i_angle_noise}));
                end
                abkf_pkg::OP_AA: begin
                    r_aa <= abkf_pkg::sat32(35'(r_aa) + 35'(r_prod));
                end
                abkf_pkg::OP_BB: begin
                    r_bb <= abkf_pkg::sat32(35'(r_bb) + 35'(r_prod));
                    r_ab <= abkf_pkg::sat32(35'(r_ab) - 35'(r_dtbb));
                    r_ba <= abkf_pkg::sat32(35'(r_ba) - 35'(r_dtbb));
                    r_s <= 33'(r_aa) + 33'({1'b0, i_measure_noise});
                    r_y <= abkf_pkg::sat32(35'(r_meas) - 35'(r_angle));
                end
                abkf_pkg::OP_DIV_START: begin
                    r_s_pos <= !r_s[32] && (r_s != 33'd0);
                    r_neg <= div_num[31];
                    r_rem_num <= {div_num_mag[31:0], 30'd0};
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= '0;
                    r_aa_old <= r_aa;
                    r_ab_old <= r_ab;
                end
                abkf_pkg::OP_DIV_STEP: begin
                    if (!trial[33]) begin
                        r_rem <= trial[32:0];
                        r_quo <= {r_quo[60:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[31:0], r_rem_num[61]};
                        r_quo <= {r_quo[60:0], 1'b0};
                    end
                    r_rem_num <= {r_rem_num[60:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                end
                abkf_pkg::OP_DIV_DONE: begin
                    if (i_cmd.div_sel) begin
                        r_k1 <= gain_q;
                    end else begin
                        r_k0 <= gain_q;
                    end
                end
                abkf_pkg::OP_UP_ANGLE: begin
                    r_angle <= abkf_pkg::sat32(35'(r_angle) + 35'(r_prod));
                end
                abkf_pkg::OP_UP_BIAS: begin
                    r_bias <= abkf_pkg::sat32(35'(r_bias) + 35'(r_prod));
                end
                abkf_pkg::OP_UP_AA: begin
                    r_aa <= abkf_pkg::sat32(35'(r_aa) - 35'(r_prod));
                end
                abkf_pkg::OP_UP_AB: begin
                    r_ab <= abkf_pkg::sat32(35'(r_ab) - 35'(r_prod));
                end
                abkf_pkg::OP_UP_BA: begin
                    r_ba <= abkf_pkg::sat32(35'(r_ba) - 35'(r_prod));
                end
                abkf_pkg::OP_UP_BB: begin
                    r_bb <= abkf_pkg::sat32(35'(r_bb) - 35'(r_prod));
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/abkf_checker.sv =====
// Port-level checker for the angle/bias Kalman filter, bound to the top level.
module abkf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_filtered_angle,
    input logic        pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_filtered_angle))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input open while result pending");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_out_valid && !o_in_ready)
        else $error("result too early");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind angle_bias_kalman_filter abkf_checker u_abkf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_filtered_angle (o_filtered_angle),
    .pready           (pready)
);
